// ===== rtl/core/sh24_pkg.sv =====
// ----------------------------------------------------------------------------
// sh24_pkg
// shared types, constants and round logic for the siphash-2-4 stream engine
// ----------------------------------------------------------------------------
package sh24_pkg;

    localparam logic [63:0] INIT_C0        = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_C1        = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C2        = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_C3        = 64'h7465646279746573;
    localparam logic [63:0] KEY_LOW_RESET  = 64'h0706050403020100;
    localparam logic [63:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
    localparam logic [63:0] FINAL_XOR      = 64'h00000000000000ff;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef enum logic [1:0] {
        CMD_ABSORB,
        CMD_FINAL,
        CMD_ABSORB_FINAL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [63:0] word;
        logic [63:0] final_block;
    } sh24_cmd_t;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_FINAL_ABSORB,
        ST_FINALISE
    } back_state_t;

    function automatic sip_state_t sip_init(input logic [63:0] klo, input logic [63:0] khi);
        sip_state_t s;
        s.v0 = klo ^ INIT_C0;
        s.v1 = khi ^ INIT_C1;
        s.v2 = klo ^ INIT_C2;
        s.v3 = khi ^ INIT_C3;
        return s;
    endfunction

    function automatic sip_state_t sip_one_round(input sip_state_t si);
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] b0;
        logic [63:0] b1;
        logic [63:0] b2;
        logic [63:0] b3;
        sip_state_t so;
        a0 = si.v0 + si.v1;
        a1 = {si.v1[50:0], si.v1[63:51]} ^ a0;
        a0 = {a0[31:0], a0[63:32]};
        a2 = si.v2 + si.v3;
        a3 = {si.v3[47:0], si.v3[63:48]} ^ a2;
        b0 = a0 + a3;
        b3 = {a3[42:0], a3[63:43]} ^ b0;
        b2 = a2 + a1;
        b1 = {a1[46:0], a1[63:47]} ^ b2;
        so.v0 = b0;
        so.v1 = b1;
        so.v2 = {b2[31:0], b2[63:32]};
        so.v3 = b3;
        return so;
    endfunction

    function automatic logic [63:0] tail_mask(input logic [3:0] count);
        logic [63:0] m;
        case (count)
            4'd1:    m = 64'h00000000000000ff;
            4'd2:    m = 64'h000000000000ffff;
            4'd3:    m = 64'h0000000000ffffff;
            4'd4:    m = 64'h00000000ffffffff;
            4'd5:    m = 64'h000000ffffffffff;
            4'd6:    m = 64'h0000ffffffffffff;
            4'd7:    m = 64'h00ffffffffffffff;
            default: m = 64'h0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/siphash_2_4_stream_top.sv =====
// ----------------------------------------------------------------------------
// siphash_2_4_stream_top
// Streaming SipHash-2-4 over little-endian 64-bit message beats. Beats enter a
// front end that tracks the message length and builds the final block, then
// pass through a four-entry command queue to a round engine that runs one
// SipRound per cycle unless a done hash waits on out_stall. The engine takes
// a new beat as it finishes the current one; a last beat adds the finalisation
// rounds (after a length-only block if it has eight bytes) before the hash is
// loaded into the output register. The queue lets the input take up to four
// beats ahead of the engine. Writing either key register reloads the hash
// state from the key and restarts the message; write keys only while the
// queue and the round engine are empty and no hash is outstanding.
// ----------------------------------------------------------------------------
module siphash_2_4_stream_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] msg_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);
    import sh24_pkg::*;

    sh24_cmd_t push_data;
    sh24_cmd_t pop_data;
    logic      push_valid;
    logic      fifo_full;
    logic      pop_valid;
    logic      pop_ready;

    sh24_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .msg_word   (msg_word),
        .byte_count (byte_count),
        .last       (last),
        .fifo_full  (fifo_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    sh24_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (fifo_full),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    sh24_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (pop_valid),
        .cmd_data   (pop_data),
        .cmd_ready  (pop_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule

// ===== rtl/core/sh24_front.sv =====
// ----------------------------------------------------------------------------
// sh24_front
// accepts message beats, tracks length and builds commands for the round engine
// ----------------------------------------------------------------------------
module sh24_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [63:0]         msg_word,
    input  logic [3:0]          byte_count,
    input  logic                last,
    input  logic                fifo_full,
    output logic                push_valid,
    output sh24_pkg::sh24_cmd_t push_data
);
    import sh24_pkg::*;

    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] len_sum;
    logic [3:0] count_sat;
    logic [3:0] len_add;
    logic       accept;

    assign in_stall   = fifo_full;
    assign push_valid = in_valid;
    assign accept     = in_valid && !fifo_full;

    assign count_sat = byte_count[3] ? 4'd8 : byte_count;
    assign len_add   = last ? count_sat : 4'd8;
    assign len_sum   = len_reg + {4'b0, len_add};

    always_comb
    begin
        push_data.word        = msg_word;
        push_data.final_block = (msg_word & tail_mask(count_sat)) | {len_sum, 56'b0};
        if (!last)
        begin
            push_data.kind = CMD_ABSORB;
        end
        else if (count_sat == 4'd8)
        begin
            push_data.kind = CMD_ABSORB_FINAL;
        end
        else
        begin
            push_data.kind = CMD_FINAL;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (cfg_we)
        begin
            len_next = 8'd0;
        end
        else if (accept)
        begin
            len_next = last ? 8'd0 : len_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 8'd0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

endmodule

// ===== rtl/core/sh24_fifo.sv =====
// ----------------------------------------------------------------------------
// sh24_fifo
// short command queue between the front end and the round engine
// ----------------------------------------------------------------------------
module sh24_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  sh24_pkg::sh24_cmd_t push_data,
    output logic                full,
    output logic                pop_valid,
    output sh24_pkg::sh24_cmd_t pop_data,
    input  logic                pop_ready
);
    import sh24_pkg::*;

    sh24_cmd_t          entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg;
    logic [FIFO_AW:0]   fill_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (fill_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_ready && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/core/sh24_back.sv =====
// ----------------------------------------------------------------------------
// sh24_back
// round engine: one sipround per cycle unless a done hash waits on out_stall, key registers and result register
// ----------------------------------------------------------------------------
module sh24_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                cmd_valid,
    input  sh24_pkg::sh24_cmd_t cmd_data,
    output logic                cmd_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [63:0]         hash_value
);
    import sh24_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    sip_state_t  v_reg;
    sip_state_t  v_next;
    sip_state_t  rnd;
    sip_state_t  base;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [63:0] m_reg;
    logic [63:0] m_next;
    logic [63:0] fb_reg;
    logic [63:0] fb_next;
    logic        pend_reg;
    logic        pend_next;
    logic [63:0] key_low_reg;
    logic [63:0] key_low_next;
    logic [63:0] key_high_reg;
    logic [63:0] key_high_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] hash_reg;
    logic        hash_load;
    logic        out_free;
    logic        can_take;
    logic        take;

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign rnd        = sip_one_round(v_reg);
    assign out_free   = !out_valid_reg || !out_stall;
    assign take       = can_take && cmd_valid;
    assign cmd_ready  = take;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_next  = cfg_data;
                REG_KEY_HIGH: key_high_next = cfg_data;
                default:      key_low_next  = key_low_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        fb_next    = fb_reg;
        pend_next  = pend_reg;
        base       = v_reg;
        can_take   = 1'b0;
        hash_load  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                can_take = 1'b1;
            end
            ST_ABSORB:
            begin
                v_next   = rnd;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd1)
                begin
                    base    = rnd;
                    base.v0 = rnd.v0 ^ m_reg;
                    v_next  = base;
                    cnt_next = 2'd0;
                    if (pend_reg)
                    begin
                        v_next.v3  = base.v3 ^ fb_reg;
                        m_next     = fb_reg;
                        state_next = ST_FINAL_ABSORB;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        can_take   = 1'b1;
                    end
                end
            end
            ST_FINAL_ABSORB:
            begin
                v_next   = rnd;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd1)
                begin
                    v_next.v0  = rnd.v0 ^ m_reg;
                    v_next.v2  = rnd.v2 ^ FINAL_XOR;
                    cnt_next   = 2'd0;
                    state_next = ST_FINALISE;
                end
            end
            ST_FINALISE:
            begin
                if (cnt_reg != 2'd3)
                begin
                    v_next   = rnd;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    hash_load  = 1'b1;
                    base       = sip_init(key_low_reg, key_high_reg);
                    v_next     = base;
                    cnt_next   = 2'd0;
                    state_next = ST_IDLE;
                    can_take   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take)
        begin
            case (cmd_data.kind)
                CMD_ABSORB, CMD_ABSORB_FINAL:
                begin
                    v_next     = base;
                    v_next.v3  = base.v3 ^ cmd_data.word;
                    m_next     = cmd_data.word;
                    fb_next    = cmd_data.final_block;
                    pend_next  = (cmd_data.kind == CMD_ABSORB_FINAL);
                    cnt_next   = 2'd0;
                    state_next = ST_ABSORB;
                end
                CMD_FINAL:
                begin
                    v_next     = base;
                    v_next.v3  = base.v3 ^ cmd_data.final_block;
                    m_next     = cmd_data.final_block;
                    pend_next  = 1'b0;
                    cnt_next   = 2'd0;
                    state_next = ST_FINAL_ABSORB;
                end
                default:
                begin
                    state_next = state_next;
                end
            endcase
        end

        if (cfg_we)
        begin
            v_next     = sip_init(key_low_next, key_high_next);
            cnt_next   = 2'd0;
            pend_next  = 1'b0;
            state_next = ST_IDLE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (hash_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hash_load)
        begin
            hash_reg <= rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;
        end
        m_reg  <= m_next;
        fb_reg <= fb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v_reg         <= sip_init(KEY_LOW_RESET, KEY_HIGH_RESET);
            cnt_reg       <= 2'd0;
            pend_reg      <= 1'b0;
            key_low_reg   <= KEY_LOW_RESET;
            key_high_reg  <= KEY_HIGH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v_reg         <= v_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
